### hw/rtl/bba_pkg.sv
// Package for the buddy block allocator: pool sizing, table entry layout,
// status codes, controller states and the size-to-order helper.
// No dependencies.
package bba_pkg;

  localparam int POOL_UNITS = 1024;
  localparam int POOL_ORDER = $clog2(POOL_UNITS + 1) - 1;
  localparam int POOL_SIZE  = 1 << POOL_ORDER;
  localparam int ADDR_W     = POOL_ORDER;
  localparam int OFF_W      = POOL_ORDER + 1;
  localparam int CMP_W      = (OFF_W > 11) ? OFF_W : 11;
  localparam int ORD_W      = 4;
  localparam int ENT_W      = ORD_W + 2;
  localparam int SIZE_W     = 11;
  localparam int FOFF_W     = 10;

  typedef struct packed {
    logic             start;
    logic             free;
    logic [ORD_W-1:0] order;
  } entry_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_BADOFF = 2'd2
  } status_e;

  typedef struct packed {
    status_e           status;
    logic [FOFF_W-1:0] offset;
    logic [ORD_W-1:0]  order;
  } result_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_SPLIT,
    S_F_RD,
    S_F_CHK,
    S_M_TEST,
    S_M_CHK,
    S_F_WR,
    S_DONE
  } state_e;

  // smallest n with 2^n >= size, size 0 counts as 1
  function automatic logic [ORD_W-1:0] size_order(input logic [SIZE_W-1:0] size);
    logic [ORD_W-1:0] n;
    n = '0;
    for (int i = SIZE_W; i >= 0; i--) begin
      if ((SIZE_W+1)'(size) <= ((SIZE_W+1)'(1) << i)) n = ORD_W'(i);
    end
    return n;
  endfunction

endpackage

### hw/rtl/buddy_block_allocator.sv
// Top level of the buddy block allocator: controller plus output word register.
// Depends on bba_pkg and bba_engine (which holds bba_ram).
//
//  channel | direction | handshake                 | word
//  in      | input     | in_valid_i / in_stall_o   | func, alloc_size, free_offset
//  out     | output    | out_valid_o / out_stall_i | status, block_offset, block_order
//
// After reset the table is cleared, one entry a cycle, with in_stall_o high.
// Allocate scans the blocks in address order, then splits the first fit down to size.
// Free reads the entry, then merges level by level; an offset that starts no block gets ST_BADOFF.
// One word is worked on at a time.
// A finished word waits in the output register; the next word is taken meanwhile.
module buddy_block_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [bba_pkg::SIZE_W-1:0]  alloc_size_i,
  input  logic [bba_pkg::FOFF_W-1:0]  free_offset_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [bba_pkg::FOFF_W-1:0]  block_offset_o,
  output logic [bba_pkg::ORD_W-1:0]   block_order_o
);

  logic             eng_idle, eng_done, slot_free, in_acc;
  bba_pkg::result_t eng_res, out_q;
  logic             out_valid_q, out_valid_d;

  assign in_stall_o = !eng_idle;
  assign in_acc     = in_valid_i && eng_idle;
  assign slot_free  = !out_valid_q || !out_stall_i;

  bba_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (in_acc),
    .func_i         (func_i),
    .alloc_size_i   (alloc_size_i),
    .free_offset_i  (free_offset_i),
    .idle_o         (eng_idle),
    .done_o         (eng_done),
    .slot_free_i    (slot_free),
    .res_o          (eng_res)
  );

  assign out_valid_d = eng_done || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (eng_done && slot_free) out_q <= eng_res;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign block_offset_o = out_q.offset;
  assign block_order_o  = out_q.order;

endmodule

### hw/rtl/bba_ram.sv
// Single-port synchronous RAM, one access per cycle, registered read data.
// No dependencies.
module bba_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/bba_engine.sv
// Allocator controller: clear pass, first-fit scan, split and merge over the
// block table held in bba_ram. Uses bba_pkg.
module bba_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        func_i,
  input  logic [bba_pkg::SIZE_W-1:0]  alloc_size_i,
  input  logic [bba_pkg::FOFF_W-1:0]  free_offset_i,
  output logic                        idle_o,
  output logic                        done_o,
  input  logic                        slot_free_i,
  output bba_pkg::result_t            res_o
);

  bba_pkg::state_e                 state_q, state_d;
  logic [bba_pkg::OFF_W-1:0]       off_q, off_d;
  logic [bba_pkg::ORD_W-1:0]       ord_q, ord_d;
  logic [bba_pkg::ORD_W-1:0]       n_q, n_d;
  bba_pkg::result_t                res_q, res_d;

  logic                            mem_we, mem_re;
  logic [bba_pkg::ADDR_W-1:0]      mem_addr;
  logic [bba_pkg::ENT_W-1:0]       mem_wdata, mem_rdata;
  bba_pkg::entry_t                 rd_e;

  logic [bba_pkg::ORD_W-1:0]       req_n;
  logic [bba_pkg::OFF_W:0]         nxt_off;
  logic [bba_pkg::OFF_W-1:0]       bit_o;
  logic [bba_pkg::OFF_W-1:0]       half_o;

  assign rd_e    = bba_pkg::entry_t'(mem_rdata);
  assign req_n   = bba_pkg::size_order(alloc_size_i);
  assign nxt_off = (bba_pkg::OFF_W+1)'(off_q) + ((bba_pkg::OFF_W+1)'(1) << rd_e.order);
  assign bit_o   = bba_pkg::OFF_W'(1) << ord_q;
  assign half_o  = bba_pkg::OFF_W'(1) << (ord_q - bba_pkg::ORD_W'(1));

  bba_ram #(
    .DEPTH (bba_pkg::POOL_SIZE),
    .AW    (bba_pkg::ADDR_W),
    .DW    (bba_pkg::ENT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // next state and datapath
  always_comb begin
    state_d = state_q;
    off_d   = off_q;
    ord_d   = ord_q;
    n_d     = n_q;
    res_d   = res_q;
    unique case (state_q)
      bba_pkg::S_CLEAR: begin
        off_d = off_q + bba_pkg::OFF_W'(1);
        if (off_q == bba_pkg::OFF_W'(bba_pkg::POOL_SIZE - 1)) begin
          state_d = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_IDLE: begin
        if (start_i) begin
          if (func_i) begin
            res_d = '{bba_pkg::ST_BADOFF, free_offset_i, '0};
            off_d = bba_pkg::OFF_W'(free_offset_i);
            if (bba_pkg::CMP_W'(free_offset_i) >= bba_pkg::CMP_W'(bba_pkg::POOL_SIZE)) begin
              state_d = bba_pkg::S_DONE;
            end else begin
              state_d = bba_pkg::S_F_RD;
            end
          end else begin
            n_d   = req_n;
            off_d = '0;
            res_d = '{bba_pkg::ST_NOFIT, '0, '0};
            if (req_n > bba_pkg::ORD_W'(bba_pkg::POOL_ORDER)) state_d = bba_pkg::S_DONE;
            else                                              state_d = bba_pkg::S_A_RD;
          end
        end
      end
      bba_pkg::S_A_RD: state_d = bba_pkg::S_A_CHK;
      bba_pkg::S_A_CHK: begin
        if (rd_e.free && rd_e.order >= n_q) begin
          ord_d   = rd_e.order;
          state_d = bba_pkg::S_A_SPLIT;
        end else if (nxt_off >= (bba_pkg::OFF_W+1)'(bba_pkg::POOL_SIZE)) begin
          state_d = bba_pkg::S_DONE;
        end else begin
          off_d   = bba_pkg::OFF_W'(nxt_off);
          state_d = bba_pkg::S_A_RD;
        end
      end
      bba_pkg::S_A_SPLIT: begin
        if (ord_q > n_q) begin
          ord_d = ord_q - bba_pkg::ORD_W'(1);
        end else begin
          res_d   = '{bba_pkg::ST_OK, bba_pkg::FOFF_W'(off_q), n_q};
          state_d = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_F_RD: state_d = bba_pkg::S_F_CHK;
      bba_pkg::S_F_CHK: begin
        if (!rd_e.start) begin
          state_d = bba_pkg::S_DONE;
        end else begin
          ord_d   = rd_e.order;
          state_d = bba_pkg::S_M_TEST;
        end
      end
      bba_pkg::S_M_TEST: begin
        if (ord_q < bba_pkg::ORD_W'(bba_pkg::POOL_ORDER)) state_d = bba_pkg::S_M_CHK;
        else                                              state_d = bba_pkg::S_F_WR;
      end
      bba_pkg::S_M_CHK: begin
        if (rd_e.start && rd_e.free && rd_e.order == ord_q) begin
          off_d   = off_q & ~bit_o;
          ord_d   = ord_q + bba_pkg::ORD_W'(1);
          state_d = bba_pkg::S_M_TEST;
        end else begin
          state_d = bba_pkg::S_F_WR;
        end
      end
      bba_pkg::S_F_WR: begin
        res_d   = '{bba_pkg::ST_OK, bba_pkg::FOFF_W'(off_q), ord_q};
        state_d = bba_pkg::S_DONE;
      end
      bba_pkg::S_DONE: begin
        if (slot_free_i) state_d = bba_pkg::S_IDLE;
      end
      default: state_d = bba_pkg::S_IDLE;
    endcase
  end

  // table port and handshake outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = off_q[bba_pkg::ADDR_W-1:0];
    mem_wdata = '0;
    unique case (state_q)
      bba_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        if (off_q == '0) begin
          mem_wdata = {1'b1, 1'b1, bba_pkg::ORD_W'(bba_pkg::POOL_ORDER)};
        end
      end
      bba_pkg::S_A_RD, bba_pkg::S_F_RD: mem_re = 1'b1;
      bba_pkg::S_A_SPLIT: begin
        mem_we = 1'b1;
        if (ord_q > n_q) begin
          // upper half becomes a free block of the next lower order
          mem_addr  = bba_pkg::ADDR_W'(off_q + half_o);
          mem_wdata = {1'b1, 1'b1, ord_q - bba_pkg::ORD_W'(1)};
        end else begin
          mem_wdata = {1'b1, 1'b0, n_q};
        end
      end
      bba_pkg::S_M_TEST: begin
        mem_re   = 1'b1;
        mem_addr = bba_pkg::ADDR_W'(off_q ^ bit_o);
      end
      bba_pkg::S_M_CHK: begin
        if (rd_e.start && rd_e.free && rd_e.order == ord_q) begin
          mem_we   = 1'b1;
          mem_addr = bba_pkg::ADDR_W'(off_q | bit_o);
        end
      end
      bba_pkg::S_F_WR: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, 1'b1, ord_q};
      end
      default: ;
    endcase
  end

  assign idle_o = (state_q == bba_pkg::S_IDLE);
  assign done_o = (state_q == bba_pkg::S_DONE);
  assign res_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::S_CLEAR;
      off_q   <= '0;
    end else begin
      state_q <= state_d;
      off_q   <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ord_q <= ord_d;
    n_q   <= n_d;
    res_q <= res_d;
  end

endmodule

### hw/rtl/bba_checker.sv
// Port-level checks for buddy_block_allocator, bound to the top level.
// Depends on bba_pkg.
module bba_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  status_o,
  input logic [bba_pkg::FOFF_W-1:0]  block_offset_o,
  input logic [bba_pkg::ORD_W-1:0]   block_order_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(block_offset_o) && $stable(block_order_o))
    else $error("output word changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == bba_pkg::ST_OK || status_o == bba_pkg::ST_NOFIT ||
      status_o == bba_pkg::ST_BADOFF))
    else $error("undefined status code");

  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == bba_pkg::ST_OK |->
      block_order_o <= bba_pkg::ORD_W'(bba_pkg::POOL_ORDER) &&
      (block_offset_o & ((bba_pkg::FOFF_W'(1) << block_order_o) - bba_pkg::FOFF_W'(1))) == '0)
    else $error("block not aligned to its size");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != bba_pkg::ST_OK |-> block_order_o == '0)
    else $error("failed word carries an order");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .block_offset_o (block_offset_o),
  .block_order_o  (block_order_o)
);
